/* sv/lvga_pkg.sv */
// Shared types and constants for the lazy voxel grid allocator.
// Used by lvga_axis and lazy_voxel_grid_allocator_unit; depends on nothing.
package lvga_pkg;

  // Grid geometry.
  localparam int GRID_X     = 64;
  localparam int GRID_Y     = 64;
  localparam int GRID_Z     = 16;
  localparam int CELL_TOTAL = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W     = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
  localparam int STRIDE_Y   = GRID_Z;
  localparam int STRIDE_X   = GRID_Y * GRID_Z;

  // Field widths.
  localparam int COORD_W   = 32;
  localparam int RECIP_W   = 24;
  localparam int IDX_X_W   = 6;
  localparam int IDX_Y_W   = 6;
  localparam int IDX_Z_W   = 4;
  localparam int IDX_MAX_W = 8;
  localparam int COUNT_W   = 9;
  localparam int HANDLE_W  = 16;
  localparam int ACTIVE_W  = 17;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 24'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_RECIP_X  = 3'd3,
    CFG_RECIP_Y  = 3'd4,
    CFG_RECIP_Z  = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_ALLOC  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_EXISTING     = 2'd0,
    ST_ALLOCATED    = 2'd1,
    ST_EMPTY        = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    SWEEP_CLEAR = 1'b0,
    SWEEP_RUN   = 1'b1
  } sweep_e;

  typedef struct packed {
    op_e                       op;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } item_t;

  typedef struct packed {
    status_e               status;
    logic [HANDLE_W-1:0]   cell_handle;
    logic [IDX_X_W-1:0]    index_x;
    logic [IDX_Y_W-1:0]    index_y;
    logic [IDX_Z_W-1:0]    index_z;
    logic [ACTIVE_W-1:0]   active_total;
  } result_t;

  // One slot of the voxel table.
  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* sv/lazy_voxel_grid_allocator_unit.sv */
// Lazy voxel grid allocator: maps a point to a voxel and allocates a cell handle on demand.
// Pipeline: 3 register stages plus the output register lie between the accepting edge and the
// result strobe; throughput one transaction per cycle while busy_o is low.
// Reset: config registers return to defaults, then a clearing pass over all CELL_TOTAL (65536)
// slots writes every table slot empty with busy_o high. The receiver cannot stall results.
module lazy_voxel_grid_allocator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lvga_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lvga_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                start_i,
  input  lvga_pkg::item_t                     item_i,
  output logic                                busy_o,
  output logic                                result_valid_o,
  output lvga_pkg::result_t                   result_o
);

  localparam logic [lvga_pkg::ADDR_W-1:0] CLR_LAST = lvga_pkg::ADDR_W'(lvga_pkg::CELL_TOTAL - 1);

  // Configuration registers.
  logic signed [lvga_pkg::COORD_W-1:0] center_x_q, center_y_q, center_z_q;
  logic [lvga_pkg::RECIP_W-1:0]        recip_x_q, recip_y_q, recip_z_q;

  // Clearing pass.
  lvga_pkg::sweep_e               sweep_q, sweep_d;
  logic [lvga_pkg::ADDR_W-1:0]    clr_cnt_q, clr_cnt_d;
  logic                           clr_we;

  // Pipeline control and payload.
  logic                           accept;
  logic                           a_vld_q, b_vld_q, c_vld_q, res_vld_q;
  lvga_pkg::op_e                  a_op_q, b_op_q, c_op_q;

  // Stage B: axis results and table address.
  logic [lvga_pkg::IDX_MAX_W-1:0] ix_raw, iy_raw, iz_raw;
  logic                           x_ok, y_ok, z_ok;
  logic [lvga_pkg::IDX_X_W-1:0]   b_ix;
  logic [lvga_pkg::IDX_Y_W-1:0]   b_iy;
  logic [lvga_pkg::IDX_Z_W-1:0]   b_iz;
  logic [lvga_pkg::ADDR_W-1:0]    b_addr;

  // Stage C: read-modify-write.
  logic [lvga_pkg::IDX_X_W-1:0]   c_ix_q;
  logic [lvga_pkg::IDX_Y_W-1:0]   c_iy_q;
  logic [lvga_pkg::IDX_Z_W-1:0]   c_iz_q;
  logic [lvga_pkg::ADDR_W-1:0]    c_addr_q;
  logic                           c_rng_q;
  logic [lvga_pkg::ENTRY_W-1:0]   rd_data;
  lvga_pkg::entry_t               entry, new_entry;
  logic                           fwd_hit, c_alloc, tbl_we;
  logic                           fw_vld_q;
  logic [lvga_pkg::ADDR_W-1:0]    fw_addr_q;
  lvga_pkg::entry_t               fw_data_q;
  logic [lvga_pkg::ACTIVE_W-1:0]  act_cnt_q, act_cnt_d;
  lvga_pkg::result_t              res_d, res_q;

  // Table write port, shared by the clearing pass and stage C.
  logic                           ram_we;
  logic [lvga_pkg::ADDR_W-1:0]    ram_waddr;
  logic [lvga_pkg::ENTRY_W-1:0]   ram_wdata;

  // ---------------------------------------------------------------------------
  // Configuration writes; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      recip_x_q  <= lvga_pkg::RECIP_RESET;
      recip_y_q  <= lvga_pkg::RECIP_RESET;
      recip_z_q  <= lvga_pkg::RECIP_RESET;
    end else if (cfg_we_i) begin
      unique case (lvga_pkg::cfg_reg_e'(cfg_idx_i))
        lvga_pkg::CFG_CENTER_X: center_x_q <= $signed(cfg_wdata_i);
        lvga_pkg::CFG_CENTER_Y: center_y_q <= $signed(cfg_wdata_i);
        lvga_pkg::CFG_CENTER_Z: center_z_q <= $signed(cfg_wdata_i);
        lvga_pkg::CFG_RECIP_X:  recip_x_q  <= cfg_wdata_i[lvga_pkg::RECIP_W-1:0];
        lvga_pkg::CFG_RECIP_Y:  recip_y_q  <= cfg_wdata_i[lvga_pkg::RECIP_W-1:0];
        lvga_pkg::CFG_RECIP_Z:  recip_z_q  <= cfg_wdata_i[lvga_pkg::RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass: sweep every slot to empty, one per cycle, after reset.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q   <= lvga_pkg::SWEEP_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      sweep_q   <= sweep_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    sweep_d   = sweep_q;
    clr_cnt_d = clr_cnt_q;
    clr_we    = 1'b0;
    unique case (sweep_q)
      lvga_pkg::SWEEP_CLEAR: begin
        clr_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_LAST) begin
          sweep_d   = lvga_pkg::SWEEP_RUN;
          clr_cnt_d = '0;
        end
      end
      lvga_pkg::SWEEP_RUN: ;
      default: sweep_d = lvga_pkg::SWEEP_CLEAR;
    endcase
  end

  assign busy_o = (sweep_q == lvga_pkg::SWEEP_CLEAR);
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // Stage valids advance every cycle; nothing downstream can stall.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      a_vld_q   <= accept;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      res_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_op_q <= item_i.op;
    end
    b_op_q <= a_op_q;
    c_op_q <= b_op_q;
  end

  // ---------------------------------------------------------------------------
  // Axis units: offset at stage A, product at stage B, index out of stage B.
  // ---------------------------------------------------------------------------
  lvga_axis u_axis_x (
    .clk_i      (clk_i),
    .load_i     (accept),
    .point_i    (item_i.point_x),
    .center_i   (center_x_q),
    .recip_i    (recip_x_q),
    .count_i    (lvga_pkg::COUNT_W'(lvga_pkg::GRID_X)),
    .idx_o      (ix_raw),
    .in_range_o (x_ok)
  );

  lvga_axis u_axis_y (
    .clk_i      (clk_i),
    .load_i     (accept),
    .point_i    (item_i.point_y),
    .center_i   (center_y_q),
    .recip_i    (recip_y_q),
    .count_i    (lvga_pkg::COUNT_W'(lvga_pkg::GRID_Y)),
    .idx_o      (iy_raw),
    .in_range_o (y_ok)
  );

  lvga_axis u_axis_z (
    .clk_i      (clk_i),
    .load_i     (accept),
    .point_i    (item_i.point_z),
    .center_i   (center_z_q),
    .recip_i    (recip_z_q),
    .count_i    (lvga_pkg::COUNT_W'(lvga_pkg::GRID_Z)),
    .idx_o      (iz_raw),
    .in_range_o (z_ok)
  );

  assign b_ix   = ix_raw[lvga_pkg::IDX_X_W-1:0];
  assign b_iy   = iy_raw[lvga_pkg::IDX_Y_W-1:0];
  assign b_iz   = iz_raw[lvga_pkg::IDX_Z_W-1:0];
  assign b_addr = lvga_pkg::ADDR_W'(lvga_pkg::ADDR_W'(b_ix) * lvga_pkg::STRIDE_X
                                  + lvga_pkg::ADDR_W'(b_iy) * lvga_pkg::STRIDE_Y
                                  + lvga_pkg::ADDR_W'(b_iz));

  // Hold the stage B result for the read-modify-write cycle; table read issues in parallel.
  always_ff @(posedge clk_i) begin
    c_ix_q   <= b_ix;
    c_iy_q   <= b_iy;
    c_iz_q   <= b_iz;
    c_addr_q <= b_addr;
    c_rng_q  <= x_ok && y_ok && z_ok;
  end

  // ---------------------------------------------------------------------------
  // Voxel table: one slot per voxel, valid bit plus handle.
  // ---------------------------------------------------------------------------
  assign ram_we    = clr_we || tbl_we;
  assign ram_waddr = clr_we ? clr_cnt_q : c_addr_q;
  assign ram_wdata = clr_we ? '0 : new_entry;

  lvga_ram #(
    .WIDTH (lvga_pkg::ENTRY_W),
    .DEPTH (lvga_pkg::CELL_TOTAL)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (b_addr),
    .rdata_o (rd_data)
  );

  // The read for this item left the table on the same edge as the previous item's write:
  // take the previous write instead when the slots match.
  assign fwd_hit = fw_vld_q && (fw_addr_q == c_addr_q);
  assign entry   = fwd_hit ? fw_data_q : lvga_pkg::entry_t'(rd_data);

  always_comb begin
    c_alloc            = 1'b0;
    act_cnt_d          = act_cnt_q;
    new_entry.valid    = 1'b1;
    new_entry.handle   = act_cnt_q[lvga_pkg::HANDLE_W-1:0];
    res_d.status       = lvga_pkg::ST_OUT_OF_RANGE;
    res_d.cell_handle  = '0;
    res_d.index_x      = '0;
    res_d.index_y      = '0;
    res_d.index_z      = '0;
    if (c_rng_q) begin
      res_d.index_x = c_ix_q;
      res_d.index_y = c_iy_q;
      res_d.index_z = c_iz_q;
      if (entry.valid) begin
        res_d.status      = lvga_pkg::ST_EXISTING;
        res_d.cell_handle = entry.handle;
      end else if (c_op_q == lvga_pkg::OP_ALLOC) begin
        c_alloc           = 1'b1;
        res_d.status      = lvga_pkg::ST_ALLOCATED;
        res_d.cell_handle = act_cnt_q[lvga_pkg::HANDLE_W-1:0];
        act_cnt_d         = act_cnt_q + 1'b1;
      end else begin
        res_d.status = lvga_pkg::ST_EMPTY;
      end
    end
    res_d.active_total = act_cnt_d;
  end

  assign tbl_we = c_vld_q && c_alloc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cnt_q <= '0;
      fw_vld_q  <= 1'b0;
    end else begin
      if (c_vld_q) begin
        act_cnt_q <= act_cnt_d;
      end
      fw_vld_q <= tbl_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      fw_addr_q <= c_addr_q;
      fw_data_q <= new_entry;
    end
    if (c_vld_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_work_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !(a_vld_q || b_vld_q || c_vld_q))
    else $error("transaction in flight during clearing pass");

  a_strobe_follows_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q |=> result_valid_o)
    else $error("read-modify-write did not produce a result strobe");

  a_count_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |=> (act_cnt_q == $past(act_cnt_q) + 1'b1))
    else $error("active count did not advance on allocation");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tbl_we |=> $stable(act_cnt_q))
    else $error("active count moved without allocation");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == lvga_pkg::ST_OUT_OF_RANGE)
      |-> (result_o.cell_handle == '0 && result_o.index_x == '0
           && result_o.index_y == '0 && result_o.index_z == '0))
    else $error("out-of-range result carries nonzero handle or index");

endmodule

/* sv/lvga_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// Read of an address written in the same cycle returns the old data. No dependencies.
module lvga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lvga_axis.sv */
// Voxel index along one axis: offset register, multiply register, then floor and range check.
// Depends on lvga_pkg.
module lvga_axis (
  input  logic                                  clk_i,
  input  logic                                  load_i,
  input  logic signed [lvga_pkg::COORD_W-1:0]   point_i,
  input  logic signed [lvga_pkg::COORD_W-1:0]   center_i,
  input  logic [lvga_pkg::RECIP_W-1:0]          recip_i,
  input  logic [lvga_pkg::COUNT_W-1:0]          count_i,
  output logic [lvga_pkg::IDX_MAX_W-1:0]        idx_o,
  output logic                                  in_range_o
);

  localparam int DIFF_W = lvga_pkg::COORD_W + 1;
  localparam int PROD_W = DIFF_W + lvga_pkg::RECIP_W + 1;
  localparam int FLR_W  = PROD_W - 32;
  localparam int SUM_W  = FLR_W + 1;

  logic signed [DIFF_W-1:0] diff_d, diff_q;
  logic signed [PROD_W-1:0] prod_q, bias_sum;
  logic signed [FLR_W-1:0]  floor_v;
  logic signed [SUM_W-1:0]  count_s, half_s, sum_v;
  logic                     low_ok, high_ok;

  assign diff_d = DIFF_W'(point_i) - DIFF_W'(center_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      diff_q <= diff_d;
    end
    prod_q <= PROD_W'(diff_q) * PROD_W'($signed({1'b0, recip_i}));
  end

  // Add one half in Q.32, then the arithmetic shift is an exact floor.
  assign bias_sum = prod_q + (PROD_W'(1) <<< 31);
  assign floor_v  = $signed(bias_sum[PROD_W-1:32]);
  assign count_s  = $signed(SUM_W'(count_i));
  assign half_s   = count_s >>> 1;
  assign sum_v    = SUM_W'(floor_v) + half_s;

  // Odd counts truncate minus one half to zero, so -1 still lands in voxel 0.
  assign low_ok     = count_i[0] ? (sum_v >= -SUM_W'(1)) : (sum_v >= SUM_W'(0));
  assign high_ok    = (sum_v < count_s);
  assign in_range_o = low_ok && high_ok;
  assign idx_o      = sum_v[SUM_W-1] ? '0 : sum_v[lvga_pkg::IDX_MAX_W-1:0];

endmodule

/* dv/lazy_voxel_grid_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lazy_voxel_grid_allocator_unit: directed and random voxel traffic.
// An in-line shadow of the grid predicts each transaction; results are checked in order.
// Depends on lvga_pkg and the lazy_voxel_grid_allocator_unit RTL.
module lazy_voxel_grid_allocator_unit_tb;

  // Pipeline depth from the accepting edge to the result strobe; leave some slack on top.
  localparam int PIPE_LATENCY = 4;
  localparam int MAX_GAP      = 18;
  localparam int PHASE_ITEMS  = 260;
  localparam int PHASE_COUNT  = 6;
  localparam int POOL_DEPTH   = 64;
  // Watchdog limit in ns; it must exceed the slowest legal run, clearing pass included.
  localparam longint RUN_LIMIT_NS = 2_000_000;
  // Register index the block does not decode.
  localparam logic [lvga_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [lvga_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [lvga_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                            start_i     = 1'b0;
  lvga_pkg::item_t                 item_i      = '0;
  logic                            busy_o;
  logic                            result_valid_o;
  lvga_pkg::result_t               result_o;

  lazy_voxel_grid_allocator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the block: grid registers, voxel table and allocation counter.
  longint                        grid_center [3] = '{0, 0, 0};
  longint                        cell_recip  [3] = '{65536, 65536, 65536};
  bit                            slot_used   [lvga_pkg::CELL_TOTAL];
  logic [lvga_pkg::HANDLE_W-1:0] slot_owner  [lvga_pkg::CELL_TOTAL];
  logic [lvga_pkg::ACTIVE_W-1:0] cells_allocated = '0;

  lvga_pkg::result_t pending_results [$];
  lvga_pkg::item_t   seen_points [$];
  int                mismatch_count = 0;
  int                burst_left = 0;

  function automatic longint axis_count(int axis);
    case (axis)
      0:       return lvga_pkg::GRID_X;
      1:       return lvga_pkg::GRID_Y;
      default: return lvga_pkg::GRID_Z;
    endcase
  endfunction

  // Voxel index along one axis, -1 when the point falls outside the grid.
  function automatic longint voxel_axis(longint p, longint c, longint recip, longint count);
    longint v;
    longint f;
    longint s;
    // Exact Q.32 offset plus one half; the arithmetic shift is an exact floor.
    v = (p - c) * recip + (longint'(1) <<< 31);
    f = v >>> 32;
    if (count % 2 == 0) begin
      s = f + count / 2;
    end else begin
      // Odd count: the half-cell offset truncates toward zero, so -1 folds onto 0.
      s = f + (count - 1) / 2;
      if (s == -1) s = 0;
      else if (s < -1) s = s + 1;
    end
    if (s < 0 || s >= count) return -1;
    return s;
  endfunction

  // Compute the expected result of one transaction and advance the shadow table.
  function automatic lvga_pkg::result_t predict_voxel(lvga_pkg::item_t it);
    lvga_pkg::result_t r;
    longint  ix;
    longint  iy;
    longint  iz;
    int      addr;
    r  = '0;
    ix = voxel_axis(longint'($signed(it.point_x)), grid_center[0], cell_recip[0],
                    lvga_pkg::GRID_X);
    iy = voxel_axis(longint'($signed(it.point_y)), grid_center[1], cell_recip[1],
                    lvga_pkg::GRID_Y);
    iz = voxel_axis(longint'($signed(it.point_z)), grid_center[2], cell_recip[2],
                    lvga_pkg::GRID_Z);
    if (ix < 0 || iy < 0 || iz < 0) begin
      // Out of range: indices and handle stay zero, the table is untouched.
      r.status = lvga_pkg::ST_OUT_OF_RANGE;
    end else begin
      addr      = int'((ix * lvga_pkg::GRID_Y + iy) * lvga_pkg::GRID_Z + iz);
      r.index_x = ix[lvga_pkg::IDX_X_W-1:0];
      r.index_y = iy[lvga_pkg::IDX_Y_W-1:0];
      r.index_z = iz[lvga_pkg::IDX_Z_W-1:0];
      if (slot_used[addr]) begin
        r.status      = lvga_pkg::ST_EXISTING;
        r.cell_handle = slot_owner[addr];
      end else if (it.op == lvga_pkg::OP_ALLOC) begin
        r.status         = lvga_pkg::ST_ALLOCATED;
        r.cell_handle    = cells_allocated[lvga_pkg::HANDLE_W-1:0];
        slot_used[addr]  = 1'b1;
        slot_owner[addr] = cells_allocated[lvga_pkg::HANDLE_W-1:0];
        cells_allocated  = cells_allocated + 1'b1;
      end else begin
        // Lookup of an empty voxel never allocates.
        r.status = lvga_pkg::ST_EMPTY;
      end
    end
    r.active_total = cells_allocated;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s, got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Check each strobed result against the oldest pending expectation.
  always @(posedge clk_i) begin : check_results
    lvga_pkg::result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", longint'(result_o), 0);
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status)
          report_mismatch("status", result_o.status, want.status);
        if (result_o.cell_handle !== want.cell_handle)
          report_mismatch("cell_handle", result_o.cell_handle, want.cell_handle);
        if (result_o.index_x !== want.index_x)
          report_mismatch("index_x", result_o.index_x, want.index_x);
        if (result_o.index_y !== want.index_y)
          report_mismatch("index_y", result_o.index_y, want.index_y);
        if (result_o.index_z !== want.index_z)
          report_mismatch("index_z", result_o.index_z, want.index_z);
        if (result_o.active_total !== want.active_total)
          report_mismatch("active_total", result_o.active_total, want.active_total);
      end
    end
  end

  // Idle cycles before the next transaction: random gaps, broken by back-to-back bursts.
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Drive one transaction at the falling edge and hold it until the block takes it.
  task automatic send_point(input lvga_pkg::item_t it);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i  <= it;
    forever begin
      @(posedge clk_i);
      if (busy_o === 1'b0) break;
    end
    pending_results = {pending_results, predict_voxel(it)};
  endtask

  // Drop start, wait for every pending result, then let the pipeline settle.
  task automatic wait_results_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // Write one register and mirror it in the shadow once the edge has taken it.
  task automatic write_reg(input logic [lvga_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lvga_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      lvga_pkg::CFG_CENTER_X: grid_center[0] = longint'($signed(data));
      lvga_pkg::CFG_CENTER_Y: grid_center[1] = longint'($signed(data));
      lvga_pkg::CFG_CENTER_Z: grid_center[2] = longint'($signed(data));
      lvga_pkg::CFG_RECIP_X:  cell_recip[0]  = longint'(data[lvga_pkg::RECIP_W-1:0]);
      lvga_pkg::CFG_RECIP_Y:  cell_recip[1]  = longint'(data[lvga_pkg::RECIP_W-1:0]);
      lvga_pkg::CFG_RECIP_Z:  cell_recip[2]  = longint'(data[lvga_pkg::RECIP_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Program all six grid registers; the unused upper bits of the reciprocals carry junk.
  task automatic set_grid(input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
                          input logic [lvga_pkg::RECIP_W-1:0] rx,
                          input logic [lvga_pkg::RECIP_W-1:0] ry,
                          input logic [lvga_pkg::RECIP_W-1:0] rz);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    write_reg(lvga_pkg::CFG_CENTER_X, cx);
    write_reg(lvga_pkg::CFG_CENTER_Y, cy);
    write_reg(lvga_pkg::CFG_CENTER_Z, cz);
    write_reg(lvga_pkg::CFG_RECIP_X, {junk, rx});
    write_reg(lvga_pkg::CFG_RECIP_Y, {~junk, ry});
    write_reg(lvga_pkg::CFG_RECIP_Z, {junk ^ 8'h5A, rz});
  endtask

  function automatic lvga_pkg::item_t mk_point(lvga_pkg::op_e op, logic [31:0] x,
                                               logic [31:0] y, logic [31:0] z);
    lvga_pkg::item_t it;
    it.op      = op;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    return it;
  endfunction

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  // Coordinate inside the grid along one axis, with a cell of slop past either edge.
  function automatic logic [31:0] axis_near(int axis);
    longint count;
    longint pitch;
    longint span;
    longint d;
    count = axis_count(axis);
    if (cell_recip[axis] == 0) pitch = longint'(1) <<< 32;
    else pitch = (longint'(1) <<< 32) / cell_recip[axis];
    span = pitch * (count + 2);
    d    = rand64() % (span + 1);
    d    = d - span / 2;
    return 32'(grid_center[axis] + d);
  endfunction

  // Coordinate within a few LSBs of the low or high grid edge along one axis.
  function automatic logic [31:0] axis_edge(int axis);
    longint count;
    longint k;
    longint d;
    int     jitter;
    count = axis_count(axis);
    if (cell_recip[axis] == 0) return $urandom;
    k      = ($urandom_range(0, 1) == 0) ? 0 : count;
    d      = ((k - count / 2) * (longint'(1) <<< 32) - (longint'(1) <<< 31)) / cell_recip[axis];
    jitter = int'($urandom_range(0, 4)) - 2;
    return 32'(grid_center[axis] + d + jitter);
  endfunction

  // Mostly well-formed points: fresh in-grid points, revisits and edge points; some noise.
  function automatic lvga_pkg::item_t random_item();
    lvga_pkg::item_t it;
    int    pick;
    int    axis;
    pick = $urandom_range(0, 99);
    if (pick < 25 && seen_points.size() > 0) begin
      it = seen_points[$urandom_range(0, seen_points.size() - 1)];
    end else if (pick < 85) begin
      it = mk_point(lvga_pkg::OP_LOOKUP, axis_near(0), axis_near(1), axis_near(2));
    end else if (pick < 93) begin
      it   = mk_point(lvga_pkg::OP_LOOKUP, axis_near(0), axis_near(1), axis_near(2));
      axis = $urandom_range(0, 2);
      case (axis)
        0:       it.point_x = axis_edge(0);
        1:       it.point_y = axis_edge(1);
        default: it.point_z = axis_edge(2);
      endcase
    end else begin
      it = mk_point(lvga_pkg::OP_LOOKUP, $urandom, $urandom, $urandom);
    end
    it.op = lvga_pkg::op_e'($urandom_range(0, 1));
    return it;
  endfunction

  // Keep a short history so later transactions hit already allocated voxels.
  task automatic remember_point(input lvga_pkg::item_t it);
    seen_points = {seen_points, it};
    if (seen_points.size() > POOL_DEPTH) void'(seen_points.pop_front());
  endtask

  // Default grid, 1 m cells centered on the origin: allocate, revisit, and probe the edges.
  task automatic test_reset_grid();
    send_point(mk_point(lvga_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0));         // empty on lookup
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h0, 32'h0, 32'h0));         // first handle
    send_point(mk_point(lvga_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0));         // existing
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h0, 32'h0, 32'h0));         // existing, no new
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h001F7FFF, 32'h0, 32'h0));  // below 31.5: top
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h001F8000, 32'h0, 32'h0));  // 31.5: out of range
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'hFFDF8000, 32'h0, 32'h0));  // -32.5: bottom cell
    send_point(mk_point(lvga_pkg::OP_LOOKUP, 32'hFFDF7FFF, 32'h0, 32'h0));  // below: out of range
    // y and z top cells
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h0, 32'h001F7FFF, 32'h00077FFF));
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h0, 32'h0, 32'h00078000));  // z at 7.5: out
    // y and z bottom cells
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h0, 32'hFFDF8000, 32'hFFF78000));
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h0, 32'h0, 32'hFFF77FFF));  // z below: out
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send_point(mk_point(lvga_pkg::OP_LOOKUP, 32'h80000000, 32'h80000000, 32'h80000000));
  endtask

  // Register extremes: zero reciprocal, largest reciprocal with centers at the limits,
  // and a write to an index the block ignores.
  task automatic test_grid_extremes();
    wait_results_drained();
    // Zero reciprocal: every point lands in the middle voxel.
    set_grid($urandom, $urandom, $urandom, 24'h0, 24'h0, 24'h0);
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    send_point(mk_point(lvga_pkg::OP_LOOKUP, 32'h80000000, 32'h7FFFFFFF, 32'h0));
    wait_results_drained();
    set_grid(32'h7FFFFFFF, 32'h80000000, 32'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h7FFFFFFF, 32'h80000000, 32'h0));
    send_point(mk_point(lvga_pkg::OP_LOOKUP, 32'h80000000, 32'h7FFFFFFF, 32'h0));
    send_point(mk_point(lvga_pkg::OP_ALLOC,  32'h7FFF8000, 32'h80008000, 32'hFFFFF800));
    wait_results_drained();
    // Ignored index: the grid must map this point exactly as before.
    write_reg(CFG_UNUSED, $urandom);
    send_point(mk_point(lvga_pkg::OP_LOOKUP, 32'h7FFFFFFF, 32'h80000000, 32'h0));
  endtask

  // Random traffic over several grid settings, one phase each.
  task automatic test_random_phases();
    lvga_pkg::item_t it;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_results_drained();
      case (phase)
        0: set_grid(32'h0, 32'h0, 32'h0, lvga_pkg::RECIP_RESET, lvga_pkg::RECIP_RESET,
                    lvga_pkg::RECIP_RESET);
        1: set_grid($urandom, $urandom, $urandom, 24'($urandom_range(1, 24'hFFFFFF)),
                    24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom_range(1, 24'hFFFFFF)));
        // Huge cells: few voxels in play, so revisits are frequent.
        2: set_grid($urandom, $urandom, $urandom, 24'($urandom_range(1, 512)),
                    24'($urandom_range(1, 512)), 24'($urandom_range(1, 512)));
        3: set_grid(32'h7FFFFFFF, 32'h80000000, $urandom, 24'hFFFFFF, 24'h1,
                    24'($urandom_range(1, 24'hFFFFFF)));
        4: set_grid($urandom_range(0, 32'h000FFFFF), $urandom_range(0, 32'h000FFFFF),
                    $urandom_range(0, 32'h000FFFFF),
                    24'($urandom_range(24'h010000, 24'h100000)),
                    24'($urandom_range(24'h010000, 24'h100000)),
                    24'($urandom_range(24'h010000, 24'h100000)));
        default: set_grid(32'h80000000, 32'h7FFFFFFF, 32'h0, 24'h1, 24'hFFFFFF,
                          lvga_pkg::RECIP_RESET);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = random_item();
        send_point(it);
        remember_point(it);
        // Hold the sender once mid-phase until every result is back.
        if (phase == 2 && n == PHASE_ITEMS / 2) wait_results_drained();
      end
    end
  endtask

  initial begin
    // Hold reset low at start, then release it on a falling edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Wait out the table clearing pass.
    forever begin
      @(posedge clk_i);
      if (busy_o === 1'b0) break;
    end
    test_reset_grid();
    test_grid_extremes();
    test_random_phases();
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: a hang or a lost result ends the run here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
